### hw/rtl/oeph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oeph_pkg
// Shared types, sizes and the key ranking function for the odd/even
// priority queue.
// ----------------------------------------------------------------------------
package oeph_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes carried in tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  // true when a strictly outranks b: odd before even, odd descending,
  // even ascending (signed)
  function automatic logic ranks_before(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
    logic r;
    if (a[0] != b[0]) begin
      r = a[0];
    end else if (a[0]) begin
      r = $signed(a) > $signed(b);
    end else begin
      r = $signed(a) < $signed(b);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/oeph_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oeph_cell
// One slot of the sorted queue row. Holds one key; on insert it keeps its
// key, takes the new key or takes its left neighbor's key; on remove it
// takes its right neighbor's key.
// ----------------------------------------------------------------------------
module oeph_cell (
  input  wire                      clk,
  input  oeph_pkg::cell_ctrl_t     ctrl,
  input  wire                      occupied,
  input  wire                      left_flag,
  input  wire [oeph_pkg::KEY_W-1:0] left_entry,
  input  wire [oeph_pkg::KEY_W-1:0] right_entry,
  output logic [oeph_pkg::KEY_W-1:0] entry,
  output logic                     flag
);
  import oeph_pkg::*;

  logic [KEY_W-1:0] entry_next;

  // new key belongs at or before this slot
  assign flag = !occupied || ranks_before(ctrl.key, entry);

  always_comb begin
    entry_next = entry;
    if (ctrl.remove) begin
      entry_next = right_entry;
    end else if (ctrl.insert && flag) begin
      entry_next = left_flag ? left_entry : ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

### hw/rtl/odd_even_priority_heap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odd_even_priority_heap
// Priority queue of signed 32-bit keys: odd keys first (larger first), then
// even keys (smaller first). Kept as a sorted row of cells.
// ----------------------------------------------------------------------------
//   channel | dir | tdata                                  | tuser
//   s_*     | in  | key[31:0]                              | cmd (0 ins, 1 rem)
//   m_*     | out | top_key, is_empty, entry_count, overflow | -
//
// At the accept edge the cell row and the count update; the result register
// samples the head cell and the count on the next edge. The next word is taken
// once no word is in flight and the result register is free or being drained.
// A stalled result holds; reset empties the queue.
// ----------------------------------------------------------------------------
module odd_even_priority_heap (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [31:0] s_tdata,   // [31:0] key
  input  wire        s_tuser,   // [0] cmd
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [47:0] m_tdata   // [31:0] top_key, [32] is_empty,
                                // [43:33] entry_count, [44] overflow, zero pad
);
  import oeph_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pend;
  logic             ovf_pend;
  logic             accept;
  logic             is_full;
  logic             is_zero;
  cell_ctrl_t       ctrl;

  logic [KEY_W-1:0] entry [CAPACITY];
  logic             flag  [CAPACITY];

  logic [KEY_W-1:0] top_key;
  logic             is_empty;
  logic [CNT_W-1:0] entry_count;
  logic             overflow;

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_full  = count == CNT_W'(CAPACITY);
  assign is_zero  = count == '0;

  assign ctrl.insert = accept && (s_tuser == CMD_INSERT) && !is_full;
  assign ctrl.remove = accept && (s_tuser == CMD_REMOVE) && !is_zero;
  assign ctrl.key    = s_tdata;

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             lf;
    logic [KEY_W-1:0] le;
    logic [KEY_W-1:0] re;

    assign occ = CNT_W'(i) < count;
    if (i == 0) begin : g_head
      assign lf = 1'b0;
      assign le = ctrl.key;
    end else begin : g_body
      assign lf = flag[i-1];
      assign le = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign re = entry[i];
    end else begin : g_inner
      assign re = entry[i+1];
    end

    oeph_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .left_flag   (lf),
      .left_entry  (le),
      .right_entry (re),
      .entry       (entry[i]),
      .flag        (flag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      pend  <= accept;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ovf_pend <= (s_tuser == CMD_INSERT) && is_full;
    end
    if (pend) begin
      top_key     <= is_zero ? EMPTY_KEY : entry[0];
      is_empty    <= is_zero;
      entry_count <= count;
      overflow    <= ovf_pend;
    end
  end

  assign m_tdata = {3'b000, overflow, entry_count, is_empty, top_key};

endmodule
`default_nettype wire

### hw/rtl/oeph_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oeph_checker
// Port-level checks for the odd/even priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module oeph_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata
);

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("no result two cycles after accept");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[32] == (m_tdata[43:33] == 11'd0)) &&
                  (!m_tdata[32] || (m_tdata[31:0] == 32'hFFFF_FFFF))))
    else $error("empty flag, count and top key disagree");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[44]) |-> (m_tdata[43:33] == 11'd1024))
    else $error("overflow reported while not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind odd_even_priority_heap oeph_checker u_oeph_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/oeph_result_checker.sv
// ----------------------------------------------------------------------------
// oeph_result_checker
// Watches both stream channels of the odd/even priority queue. Every command
// word taken in is run through a behavioral binary heap kept here. The status
// it gives (top key, empty flag, count, overflow) is queued, and each result
// word is compared field by field against the oldest queued status.
// ----------------------------------------------------------------------------
module oeph_result_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [31:0] s_tdata,   // [31:0] key
  input  wire        s_tuser,   // [0] cmd
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [47:0] m_tdata,   // [31:0] top_key, [32] is_empty,
                                // [43:33] entry_count, [44] overflow
  output int         awaited,
  output int         errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import oeph_pkg::*;

  // same bit order as m_tdata, lowest field last
  typedef struct packed {
    logic             overflow;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    logic [KEY_W-1:0] top_key;
  } heap_status_t;

  logic [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned      heap_fill;
  heap_status_t     status_q [$];

  // odd before even; odd descending, even ascending, both signed
  function automatic logic outranks(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] ua;
    logic [KEY_W-1:0] ub;
    ua = a ^ {1'b1, {(KEY_W-1){1'b0}}};
    ub = b ^ {1'b1, {(KEY_W-1){1'b0}}};
    if (a[0] != b[0]) return a[0];
    if (a[0]) return ua > ub;
    return ua < ub;
  endfunction

  task automatic heap_apply(input logic cmd, input logic [KEY_W-1:0] key,
                            output heap_status_t st);
    int unsigned      pos;
    int unsigned      par;
    int unsigned      lc;
    int unsigned      rc;
    int unsigned      pick;
    logic [KEY_W-1:0] tmp;
    st = '0;
    if (cmd == CMD_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        st.overflow = 1'b1;
      end else begin
        heap_keys[heap_fill] = key;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!outranks(heap_keys[pos], heap_keys[par])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[par];
          heap_keys[par] = tmp;
          pos = par;
        end
      end
    end else if (heap_fill > 0) begin
      heap_fill--;
      heap_keys[0] = heap_keys[heap_fill];
      pos = 0;
      forever begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= heap_fill) break;
        // ties go to the right child
        if (rc >= heap_fill || outranks(heap_keys[lc], heap_keys[rc])) begin
          pick = lc;
        end else begin
          pick = rc;
        end
        if (!outranks(heap_keys[pick], heap_keys[pos])) break;
        tmp = heap_keys[pick];
        heap_keys[pick] = heap_keys[pos];
        heap_keys[pos] = tmp;
        pos = pick;
      end
    end
    st.is_empty    = (heap_fill == 0);
    st.top_key     = (heap_fill == 0) ? EMPTY_KEY : heap_keys[0];
    st.entry_count = heap_fill[CNT_W-1:0];
  endtask

  task automatic check_field(input string name, input longint want,
                             input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : track
    heap_status_t want;
    heap_status_t got;
    if (rst) begin
      heap_fill = 0;
      status_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[44:0];
        if (status_q.size() == 0) begin
          $error("result word with none expected: %h", m_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("top_key", $signed(want.top_key), $signed(got.top_key));
          check_field("is_empty", want.is_empty, got.is_empty);
          check_field("entry_count", want.entry_count, got.entry_count);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (s_tvalid && s_tready) begin
        heap_apply(s_tuser, s_tdata, want);
        status_q = {status_q, want};
      end
    end
    awaited = status_q.size();
  end

endmodule

### tb/sv/tb_odd_even_priority_heap.sv
// ----------------------------------------------------------------------------
// tb_odd_even_priority_heap
// Drives command words into the odd/even priority queue: a directed run over
// key extremes, parity, duplicates and empty removes, then random traffic that
// grows the queue to a few hundred entries and drains it again.
// Both sides idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_odd_even_priority_heap;
  timeunit 1ns;
  timeprecision 1ps;

  import oeph_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 20;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        s_tuser  = CMD_INSERT;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;

  int awaited;
  int errors;
  int stall_cycles = 0;
  int stored       = 0;
  bit no_idle      = 1'b0;
  bit hold_rx      = 1'b0;

  always #10 clk = ~clk;

  odd_even_priority_heap dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  oeph_result_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .awaited  (awaited),
    .errors   (errors)
  );

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return 32'($urandom_range(0, 32)) - 32'd16;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h8000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h7fff_fffe;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [31:0] key);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_INSERT) begin
      if (stored < CAPACITY) stored++;
    end else if (stored > 0) begin
      stored--;
    end
  endtask

  task automatic random_word(input int insert_pct);
    logic cmd;
    cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
    send_word(cmd, rand_key());
  endtask

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : rx_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : tx_side
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty remove, extremes, parity, duplicates, drain past empty
    send_word(CMD_REMOVE, 32'h1234_5678);
    send_word(CMD_INSERT, 32'h7fff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_INSERT, 32'h8000_0001);
    send_word(CMD_INSERT, 32'h7fff_fffe);
    send_word(CMD_INSERT, 32'h0000_0000);
    send_word(CMD_INSERT, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'h0000_0001);
    send_word(CMD_INSERT, 32'hffff_fffe);
    send_word(CMD_INSERT, 32'h0000_0001);
    send_word(CMD_INSERT, 32'hffff_fffe);
    repeat (11) send_word(CMD_REMOVE, rand_key());
    send_word(CMD_REMOVE, '1);

    // mixed traffic, with one long receiver hold-off
    for (int i = 0; i < 250; i++) begin
      if (i == 80) hold_rx = 1'b1;
      random_word(55);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);

    // grow to a few hundred entries
    repeat (250) random_word(90);
    repeat (4) begin
      send_word(CMD_REMOVE, rand_key());
      send_word(CMD_INSERT, rand_key());
      send_word(CMD_INSERT, rand_key());
    end

    // drain to empty and past it
    while (stored > 0) random_word(10);
    repeat (3) send_word(CMD_REMOVE, rand_key());

    no_idle = 1'b1;
    repeat (100) random_word(60);
    no_idle = 1'b0;
    repeat (50) random_word(50);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/oeph_pkg.sv
hw/rtl/oeph_cell.sv
hw/rtl/odd_even_priority_heap.sv
hw/rtl/oeph_checker.sv
tb/sv/oeph_result_checker.sv
tb/sv/tb_odd_even_priority_heap.sv
